FILE: rtl/multi_region_bump_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef MULTI_REGION_BUMP_ALLOCATOR_ASSERT_SVH
`define MULTI_REGION_BUMP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MRBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define MRBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

FILE: rtl/mrba_pkg.sv
`timescale 1ns / 1ps

package mrba_pkg;

    // Field widths of the stream words.
    localparam int LEN_W    = 25;
    localparam int DATA_W   = 32;
    localparam int NEXT_W   = 33;
    localparam int SUM_W    = 34;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;

    localparam logic [LEN_W-1:0] DEFAULT_ARENA_RESET = LEN_W'(1 << 15);

    // Request codes.
    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_LOCK   = 2'd2,
        ACT_UNLOCK = 2'd3
    } t_action;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_NO_MATCH  = 2'd3
    } t_status;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LIMIT  = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    // One arena table entry as stored in the table memory.
    typedef struct packed {
        logic [SUM_W-1:0]  last_block;
        logic [LEN_W-1:0]  used;
        logic [LEN_W-1:0]  size;
        logic [NEXT_W-1:0] base;
    } t_entry;

endpackage

FILE: rtl/multi_region_bump_allocator.sv
`timescale 1ns / 1ps

// Bump-pointer arena allocator over a table of up to MAX_ARENAS arenas. Each request word
// gives one result word. An allocation scans the open arenas newest first for one with
// room (a locked arena offers none) and otherwise opens a new arena at the region pointer;
// a free rolls an arena's offset back when the address is its last block; lock and unlock
// act on the newest arena whose used part holds the address. The arena table lives in a
// single-port memory with a registered read, read one entry per cycle during the scan.
// A request is accepted only in the idle state, so the next one waits until the last has
// passed its scan and update steps. The result sits in an output register; a new request
// may be accepted while it waits to be taken. Configuration writes are taken in every
// cycle and must only arrive while the block is idle.
module multi_region_bump_allocator #(
    parameter int MAX_ARENAS = 16,
    parameter int ADDR_BITS  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request stream.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: action[1:0], length[26:2], address[58:27], zero pad[63:59]
    input  logic [mrba_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // Result stream.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: block_address[31:0], status[33:32], arena_index[37:34], zero pad[39:38]
    output logic [mrba_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mrba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mrba_pkg::DATA_W-1:0]      i_cfg_data
);

    import mrba_pkg::*;

    localparam int IW = (MAX_ARENAS > 1) ? $clog2(MAX_ARENAS) : 1;
    localparam int CW = $clog2(MAX_ARENAS + 1);
    localparam logic [SUM_W-1:0] ADDR_MASK =
        (ADDR_BITS >= SUM_W) ? {SUM_W{1'b1}} : ((SUM_W'(1) << ADDR_BITS) - SUM_W'(1));

    // Configuration registers. The region base only matters through the region pointer.
    logic [LEN_W-1:0]  r_default;
    logic [DATA_W-1:0] r_region_limit;

    // Allocator control state.
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count;
    logic [NEXT_W-1:0]   r_next;
    logic [MAX_ARENAS-1:0] r_locked;
    logic [MAX_ARENAS-1:0] r_last_valid;
    logic [CW-1:0]       r_iss;
    logic                r_chk_vld;
    logic [IW-1:0]       r_chk_idx;

    // Request being worked on and the scan outcome.
    t_action             r_act;
    logic [LEN_W-1:0]    r_len;
    logic [SUM_W-1:0]    r_addr;
    logic [LEN_W-1:0]    r_new_size;
    logic                r_hit;
    t_entry              r_ent;
    logic [IW-1:0]       r_idx;

    // Output register.
    logic                   r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Table memory.
    t_entry              r_mem [MAX_ARENAS];
    t_entry              r_rd_data;

    logic                in_acc;
    logic                out_free;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic [CW-1:0]       iss_dec;
    logic                hit_now;
    logic                scan_done;
    logic                upd_go;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    t_entry              wr_data;
    logic [LEN_W-1:0]    room;
    logic [SUM_W-1:0]    rd_end;
    logic [SUM_W-1:0]    hit_sum;
    logic [SUM_W-1:0]    miss_sum;
    logic                table_full;
    logic                exhausted;
    logic [IW-1:0]       new_idx;
    logic [DATA_W-1:0]   res_block;
    t_status             res_status;
    logic [IW-1:0]       res_idx;
    logic [IW+3:0]       res_idx_ext;
    logic                set_lock;
    logic                clr_lock;
    logic                set_last;
    logic [IW-1:0]       flag_idx;
    t_action             in_act;
    logic [LEN_W-1:0]    in_len;
    logic                out_fail;

    assign in_act   = t_action'(i_s_tdata[1:0]);
    assign in_len   = i_s_tdata[26:2];
    assign in_acc   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_vld || i_m_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_vld;
    assign o_m_tdata   = r_out_data;
    assign out_fail    = r_out_vld && (r_out_data[33:32] != ST_OK);

    // Scan address: entries are read from newest to oldest.
    assign iss_dec = r_iss - CW'(1);
    assign rd_addr = iss_dec[IW-1:0];

    // Match test on the entry just read from the table.
    always_comb begin
        if (r_locked[r_chk_idx] || (r_rd_data.used > r_rd_data.size)) begin
            room = '0;
        end else begin
            room = r_rd_data.size - r_rd_data.used;
        end
        rd_end = SUM_W'(r_rd_data.base) + SUM_W'(r_rd_data.used);
        unique case (r_act)
            ACT_ALLOC: hit_now = (room >= r_len);
            ACT_FREE: begin
                hit_now = r_last_valid[r_chk_idx] && (r_rd_data.last_block == r_addr);
            end
            ACT_LOCK, ACT_UNLOCK: begin
                hit_now = (r_addr >= SUM_W'(r_rd_data.base)) && (r_addr < rd_end);
            end
        endcase
        hit_now   = hit_now && r_chk_vld;
        scan_done = hit_now || (r_iss == '0);
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_acc) begin
                n_state = S_SCAN;
            end
            S_SCAN:   if (scan_done) begin
                n_state = S_UPDATE;
            end
            S_UPDATE: if (out_free) begin
                n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_tready = (r_state == S_IDLE);
        rd_en      = (r_state == S_SCAN) && (r_iss != '0);
        upd_go     = (r_state == S_UPDATE) && out_free;
    end

    // Update step: write back the matched entry or open a new arena.
    always_comb begin
        hit_sum    = (SUM_W'(r_ent.base) + SUM_W'(r_ent.used)) & ADDR_MASK;
        miss_sum   = SUM_W'(r_next) + SUM_W'(r_new_size);
        table_full = (r_count >= CW'(MAX_ARENAS));
        exhausted  = miss_sum > (SUM_W'(r_region_limit) + SUM_W'(1));
        new_idx    = r_count[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_idx;
        wr_data    = r_ent;
        res_block  = '0;
        res_status = ST_OK;
        res_idx    = r_idx;
        set_lock   = 1'b0;
        clr_lock   = 1'b0;
        set_last   = 1'b0;
        flag_idx   = r_idx;
        if (r_hit) begin
            unique case (r_act)
                ACT_ALLOC: begin
                    wr_en              = 1'b1;
                    wr_data.used       = r_ent.used + r_len;
                    wr_data.last_block = hit_sum;
                    res_block          = hit_sum[DATA_W-1:0];
                    set_last           = 1'b1;
                end
                ACT_FREE: begin
                    wr_en        = 1'b1;
                    wr_data.used = LEN_W'(r_addr - SUM_W'(r_ent.base));
                end
                ACT_LOCK:   set_lock = 1'b1;
                ACT_UNLOCK: clr_lock = 1'b1;
            endcase
        end else if (r_act == ACT_ALLOC) begin
            res_idx = '0;
            if (table_full) begin
                res_status = ST_TABLE_FULL;
            end else if (exhausted) begin
                res_status = ST_EXHAUSTED;
            end else begin
                wr_en              = 1'b1;
                wr_addr            = new_idx;
                wr_data.base       = r_next;
                wr_data.size       = r_new_size;
                wr_data.used       = r_len;
                wr_data.last_block = SUM_W'(r_next) & ADDR_MASK;
                res_block          = wr_data.last_block[DATA_W-1:0];
                res_idx            = new_idx;
                clr_lock           = 1'b1;
                set_last           = 1'b1;
                flag_idx           = new_idx;
            end
        end else begin
            res_status = ST_NO_MATCH;
            res_idx    = '0;
        end
        wr_en       = wr_en && upd_go;
        res_idx_ext = {4'b0, res_idx};
    end

    // Table memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_default      <= DEFAULT_ARENA_RESET;
            r_region_limit <= '1;
            r_count        <= '0;
            r_next         <= '0;
            r_locked       <= '0;
            r_last_valid   <= '0;
            r_iss          <= '0;
            r_chk_vld      <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            r_state <= n_state;

            // Configuration writes.
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_DEFAULT_BYTES) begin
                    r_default <= i_cfg_data[LEN_W-1:0];
                end else if (i_cfg_index == CFG_REGION_BASE) begin
                    if (r_count == '0) begin
                        r_next <= NEXT_W'(i_cfg_data);
                    end
                end else if (i_cfg_index == CFG_REGION_LIMIT) begin
                    r_region_limit <= i_cfg_data;
                end
            end

            // Scan pointer and read tracking.
            if (in_acc) begin
                r_iss     <= r_count;
                r_chk_vld <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_chk_vld <= rd_en;
                if (rd_en) begin
                    r_iss <= iss_dec;
                end
            end

            // Arena flags and table growth.
            if (upd_go) begin
                if (set_lock) begin
                    r_locked[flag_idx] <= 1'b1;
                end
                if (clr_lock) begin
                    r_locked[flag_idx] <= 1'b0;
                end
                if (set_last) begin
                    r_last_valid[flag_idx] <= 1'b1;
                end
                if (!r_hit && (r_act == ACT_ALLOC) && !table_full && !exhausted) begin
                    r_count <= r_count + CW'(1);
                    r_next  <= miss_sum[NEXT_W-1:0];
                end
            end

            // Result handshake.
            if (upd_go) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act      <= in_act;
            r_len      <= in_len;
            r_addr     <= SUM_W'(i_s_tdata[58:27]) & ADDR_MASK;
            r_new_size <= (in_len > r_default) ? in_len : r_default;
        end
        if (rd_en) begin
            r_chk_idx <= rd_addr;
        end
        if ((r_state == S_SCAN) && scan_done) begin
            r_hit <= hit_now;
            r_ent <= r_rd_data;
            r_idx <= r_chk_idx;
        end
        if (upd_go) begin
            r_out_data <= {2'b00, res_idx_ext[3:0], res_status, res_block};
        end
    end

    `include "multi_region_bump_allocator_assert.svh"

    `MRBA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_ARENAS))
    `MRBA_ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, in_acc, r_state == S_SCAN)
    `MRBA_ASSERT_NEXT(a_update_emits, i_clk, i_rst_n, upd_go, r_out_vld && (r_state == S_IDLE))
    `MRBA_ASSERT_NOW(a_fail_is_zero, i_clk, i_rst_n, out_fail, {r_out_data[37:34], r_out_data[31:0]} == '0)
    `MRBA_ASSERT_NOW(a_no_write_while_scan, i_clk, i_rst_n, r_state == S_SCAN, !wr_en)

endmodule

FILE: dv/mrba_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register channels of the allocator. It keeps its own
// copy of the arena table and the registers, predicts one result word per accepted
// request word and compares every accepted result word with the oldest prediction.
module mrba_checker #(
    parameter int MAX_ARENAS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // tdata: action[1:0], length[26:2], address[58:27], zero pad[63:59]
    input  logic [mrba_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: block_address[31:0], status[33:32], arena_index[37:34], zero pad[39:38]
    input  logic [mrba_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [mrba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mrba_pkg::DATA_W-1:0]      i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);

    import mrba_pkg::*;

    typedef struct packed {
        t_action           action;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] address;
    } t_alloc_request;

    typedef struct packed {
        logic [DATA_W-1:0] block_address;
        t_status           status;
        logic [3:0]        arena_index;
    } t_alloc_result;

    // Register copies. The region base only matters through the cursor.
    logic [LEN_W-1:0]  new_arena_bytes;
    logic [DATA_W-1:0] region_ceiling;

    // Arena table copy.
    logic [NEXT_W-1:0] arena_start   [MAX_ARENAS];
    logic [LEN_W-1:0]  arena_span    [MAX_ARENAS];
    logic [LEN_W-1:0]  arena_fill    [MAX_ARENAS];
    logic              arena_held    [MAX_ARENAS];
    logic [DATA_W-1:0] arena_tail    [MAX_ARENAS];
    logic              arena_tail_ok [MAX_ARENAS];
    int                open_arenas;
    logic [NEXT_W-1:0] region_cursor;

    t_alloc_result awaited_results [$];
    int            fails;
    int            checked;

    // Hands out a block at the arena's current offset and bumps the offset.
    function automatic logic [DATA_W-1:0] bump_arena(input int i, input logic [LEN_W-1:0] len);
        logic [SUM_W-1:0] tip;
        tip = SUM_W'(arena_start[i]) + SUM_W'(arena_fill[i]);
        arena_fill[i]    = arena_fill[i] + len;
        arena_tail[i]    = tip[DATA_W-1:0];
        arena_tail_ok[i] = 1'b1;
        return tip[DATA_W-1:0];
    endfunction

    // Works out the result of one request and updates the table copy.
    task automatic predict_result(input t_alloc_request req, output t_alloc_result res);
        logic [LEN_W-1:0] room;
        logic [LEN_W-1:0] span;
        logic [63:0]      wide_addr;
        logic [63:0]      reach;
        int               i;
        bit               found;
        res.block_address = '0;
        res.status        = ST_OK;
        res.arena_index   = '0;
        found             = 1'b0;
        wide_addr         = 64'(req.address);
        case (req.action)
            ACT_ALLOC: begin
                // Newest arena first; a locked or overfilled arena offers no room.
                for (i = open_arenas - 1; i >= 0; i--) begin
                    if (!found) begin
                        room = (arena_held[i] || arena_fill[i] > arena_span[i]) ?
                               '0 : arena_span[i] - arena_fill[i];
                        if (room >= req.length) begin
                            found             = 1'b1;
                            res.block_address = bump_arena(i, req.length);
                            res.arena_index   = 4'(i);
                        end
                    end
                end
                // Nothing fits: open a new arena at the region cursor if possible.
                if (!found) begin
                    span  = (req.length > new_arena_bytes) ? req.length : new_arena_bytes;
                    reach = 64'(region_cursor) + 64'(span);
                    if (open_arenas >= MAX_ARENAS) begin
                        res.status = ST_TABLE_FULL;
                    end else if (reach > 64'(region_ceiling) + 64'd1) begin
                        res.status = ST_EXHAUSTED;
                    end else begin
                        i                = open_arenas;
                        arena_start[i]   = region_cursor;
                        arena_span[i]    = span;
                        arena_fill[i]    = '0;
                        arena_held[i]    = 1'b0;
                        arena_tail_ok[i] = 1'b0;
                        arena_tail[i]    = '0;
                        open_arenas++;
                        region_cursor     = reach[NEXT_W-1:0];
                        res.block_address = bump_arena(i, req.length);
                        res.arena_index   = 4'(i);
                    end
                end
            end
            ACT_FREE: begin
                // Only the last block of an arena rolls its offset back.
                for (i = open_arenas - 1; i >= 0; i--) begin
                    if (!found && arena_tail_ok[i] && arena_tail[i] == req.address) begin
                        found           = 1'b1;
                        reach           = wide_addr - 64'(arena_start[i]);
                        arena_fill[i]   = reach[LEN_W-1:0];
                        res.arena_index = 4'(i);
                    end
                end
                if (!found) res.status = ST_NO_MATCH;
            end
            ACT_LOCK, ACT_UNLOCK: begin
                // The newest arena whose used part holds the address.
                for (i = open_arenas - 1; i >= 0; i--) begin
                    if (!found && wide_addr >= 64'(arena_start[i]) &&
                        wide_addr < 64'(arena_start[i]) + 64'(arena_fill[i])) begin
                        found           = 1'b1;
                        arena_held[i]   = (req.action == ACT_LOCK);
                        res.arena_index = 4'(i);
                    end
                end
                if (!found) res.status = ST_NO_MATCH;
            end
            default: res.status = ST_NO_MATCH;
        endcase
    endtask

    // Channel monitor: register writes, result comparison, then prediction.
    always @(posedge i_clk) begin : watch
        t_alloc_request req;
        t_alloc_result  got;
        t_alloc_result  want;
        if (!i_rst_n) begin
            new_arena_bytes = DEFAULT_ARENA_RESET;
            region_ceiling  = '1;
            for (int i = 0; i < MAX_ARENAS; i++) begin
                arena_start[i]   = '0;
                arena_span[i]    = '0;
                arena_fill[i]    = '0;
                arena_held[i]    = 1'b0;
                arena_tail[i]    = '0;
                arena_tail_ok[i] = 1'b0;
            end
            open_arenas   = 0;
            region_cursor = '0;
            awaited_results.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEFAULT_BYTES: new_arena_bytes = i_cfg_data[LEN_W-1:0];
                    CFG_REGION_BASE: begin
                        // The cursor follows the base only while the table is empty.
                        if (open_arenas == 0) region_cursor = NEXT_W'(i_cfg_data);
                    end
                    CFG_REGION_LIMIT: region_ceiling = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_m_tvalid && i_m_tready) begin
                got.block_address = i_m_tdata[31:0];
                got.status        = t_status'(i_m_tdata[33:32]);
                got.arena_index   = i_m_tdata[37:34];
                if (awaited_results.size() == 0) begin
                    $display("%0t: result word %h arrived with nothing awaited", $time, i_m_tdata);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (got.block_address !== want.block_address) begin
                        $display("%0t: block_address expected %h, got %h",
                                 $time, want.block_address, got.block_address);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, got.status);
                        fails++;
                    end
                    if (got.arena_index !== want.arena_index) begin
                        $display("%0t: arena_index expected %0d, got %0d",
                                 $time, want.arena_index, got.arena_index);
                        fails++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                req.action  = t_action'(i_s_tdata[1:0]);
                req.length  = i_s_tdata[26:2];
                req.address = i_s_tdata[58:27];
                predict_result(req, want);
                awaited_results.insert(awaited_results.size(), want);
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import mrba_pkg::*;

    localparam int MAX_ARENAS  = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int END_CYCLES  = 2 * (MAX_ARENAS + 3);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [LEN_W-1:0]     LEN_MAX    = LEN_W'(1 << 24);

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data  = '0;
    logic                   cfg_ready;

    int fail_count;
    int pending;
    int checked;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold = 0;
    int idle_cycles = 0;
    int action_count [4];
    int reg_writes = 0;

    // Recently handed-out blocks, used to aim frees, locks and unlocks.
    logic [DATA_W-1:0] recent_blocks [$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multi_region_bump_allocator #(
        .MAX_ARENAS(MAX_ARENAS),
        .ADDR_BITS (32)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    mrba_checker #(
        .MAX_ARENAS(MAX_ARENAS)
    ) alloc_monitor (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Result side: after each taken word, stall for a random number of cycles.
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_hold = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) rx_hold = rx_idle ? $urandom_range(0, 19) : 0;
            else if (!m_tready && rx_hold > 0) rx_hold--;
            m_tready <= (rx_hold == 0);
        end
    end

    // Block addresses are recorded on the falling edge before the word is taken, away from
    // the edge where the stimulus reads them.
    always @(negedge clk) begin
        if (rst_n && m_tvalid && m_tready && t_status'(m_tdata[33:32]) == ST_OK &&
            m_tdata[31:0] != '0) begin
            recent_blocks.insert(recent_blocks.size(), m_tdata[31:0]);
            if (recent_blocks.size() > 32) recent_blocks.pop_front();
        end
    end

    // Watchdog on cycles in which no channel moves a word.
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                     (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("multi_region_bump_allocator regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one request word after a random gap.
    task automatic send_request(input t_action act, input logic [LEN_W-1:0] len,
                                input logic [DATA_W-1:0] addr);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, addr, len, act};
        do @(posedge clk); while (!s_tready);
        action_count[act]++;
    endtask

    // Writes one register; only called while nothing is outstanding.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // Holds the request side until every awaited result word has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Random requests: mostly small allocations, frees aimed at recent blocks and locks
    // or unlocks aimed inside them, with some noise addresses.
    task automatic run_random(input int count);
        int               n;
        int               r;
        t_action          act;
        logic [LEN_W-1:0] len;
        logic [DATA_W-1:0] addr;
        for (n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle <= ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) == 0) drain();
            r   = $urandom_range(0, 99);
            act = (r < 50) ? ACT_ALLOC : (r < 75) ? ACT_FREE : (r < 87) ? ACT_LOCK : ACT_UNLOCK;
            r = $urandom_range(0, 99);
            if (act != ACT_ALLOC)  len = LEN_W'($urandom());
            else if (r < 10)       len = '0;
            else if (r < 70)       len = LEN_W'($urandom_range(1, 255));
            else if (r < 95)       len = LEN_W'($urandom_range(256, 8191));
            else if (r < 98)       len = LEN_W'($urandom_range(8192, 1 << 24));
            else                   len = LEN_MAX;
            r = $urandom_range(0, 99);
            if (act == ACT_ALLOC || recent_blocks.size() == 0 || r >= 75) begin
                addr = $urandom();
            end else if (r < 45) begin
                addr = recent_blocks[$];
            end else if (r < 65) begin
                addr = recent_blocks[$urandom_range(0, recent_blocks.size() - 1)];
                if (act != ACT_FREE) addr = addr + $urandom_range(0, 3);
            end else begin
                addr = (r < 70) ? '0 : '1;
            end
            send_request(act, len, addr);
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: free, lock and unlock find nothing.
        send_request(ACT_FREE, '0, '0);
        send_request(ACT_LOCK, '0, '0);
        send_request(ACT_UNLOCK, LEN_MAX, '1);
        drain();

        // Region base at the top of the address space: even the first arena runs past
        // the limit.
        write_reg(CFG_REGION_BASE, '1);
        send_request(ACT_ALLOC, '0, '0);
        drain();

        // Region from address zero with one-byte arenas.
        write_reg(CFG_REGION_BASE, '0);
        write_reg(CFG_DEFAULT_BYTES, 32'd1);
        send_request(ACT_ALLOC, '0, '0);
        send_request(ACT_ALLOC, LEN_W'(1), '0);
        send_request(ACT_ALLOC, LEN_W'(1), '0);
        send_request(ACT_ALLOC, '0, '0);
        send_request(ACT_FREE, '0, 32'd2);
        send_request(ACT_FREE, '0, 32'd1);
        send_request(ACT_LOCK, '0, 32'd0);
        send_request(ACT_UNLOCK, '0, 32'd0);
        send_request(ACT_LOCK, '0, 32'd1);
        // A zero-length request is served even by a locked arena.
        send_request(ACT_ALLOC, '0, '0);
        drain();

        // Largest default and a zero limit: every new arena is refused. The base write
        // is ignored with arenas open, and the unused index is ignored altogether.
        write_reg(CFG_DEFAULT_BYTES, 32'(LEN_MAX));
        write_reg(CFG_REGION_LIMIT, '0);
        write_reg(CFG_REGION_BASE, 32'h1234_5678);
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        send_request(ACT_ALLOC, LEN_W'(5), '0);
        send_request(ACT_ALLOC, LEN_MAX, '1);
        send_request(ACT_UNLOCK, '0, 32'd1);
        send_request(ACT_ALLOC, '0, '0);
        drain();

        // Full region again with the reset default size.
        write_reg(CFG_REGION_LIMIT, '1);
        write_reg(CFG_DEFAULT_BYTES, 32'(DEFAULT_ARENA_RESET));
        send_request(ACT_ALLOC, LEN_MAX, '0);
        send_request(ACT_ALLOC, LEN_W'(100), '0);
        send_request(ACT_LOCK, '0, 32'h0100_0034);
        send_request(ACT_ALLOC, LEN_W'(10), '0);
        send_request(ACT_FREE, '0, '1);
        send_request(ACT_LOCK, '0, '1);
        send_request(ACT_FREE, '0, 32'd2);
        send_request(ACT_UNLOCK, '0, 32'h0100_0034);
        drain();

        // Random phases under several register settings.
        run_random(250);
        drain();
        write_reg(CFG_REGION_LIMIT, '0);
        run_random(150);
        drain();
        write_reg(CFG_REGION_LIMIT, '1);
        write_reg(CFG_DEFAULT_BYTES, 32'd4096);
        run_random(250);
        drain();
        write_reg(CFG_DEFAULT_BYTES, 32'($urandom_range(1, 1 << 24)));
        write_reg(CFG_REGION_BASE, '0);
        run_random(300);
        drain();
        write_reg(CFG_DEFAULT_BYTES, 32'd1);
        write_reg(CFG_REGION_LIMIT, $urandom());
        run_random(350);
        drain();
        repeat (END_CYCLES) @(posedge clk);

        $display("Covered %0d requests (%0d alloc, %0d free, %0d lock, %0d unlock), %0d writes.",
                 action_count[ACT_ALLOC] + action_count[ACT_FREE] + action_count[ACT_LOCK] +
                 action_count[ACT_UNLOCK], action_count[ACT_ALLOC], action_count[ACT_FREE],
                 action_count[ACT_LOCK], action_count[ACT_UNLOCK], reg_writes);
        $display("Compared %0d result words; %0d mismatches, %0d still awaited.",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("multi_region_bump_allocator regression: pass");
        end else begin
            $display("multi_region_bump_allocator regression: fail");
        end
        $finish;
    end

endmodule
